[hdl/tspat_pkg.sv]
package tspat_pkg;

    // Section constants
    localparam logic [7:0]  PAT_TABLE_ID      = 8'h00;
    localparam logic [12:0] NIT_PID_DEFAULT   = 13'h0010;
    localparam logic [11:0] MIN_SECTION_LEN   = 12'd9;
    localparam logic [15:0] PREFIX_BYTES      = 16'd3;

    // Byte positions inside the section
    localparam logic [11:0] POS_LEN_HI        = 12'd1;
    localparam logic [11:0] POS_LEN_LO        = 12'd2;
    localparam logic [11:0] POS_TSID_LO       = 12'd4;
    localparam logic [11:0] POS_VERSION       = 12'd5;
    localparam logic [11:0] POS_SECTION       = 12'd6;
    localparam logic [11:0] POS_LAST_SECTION  = 12'd7;
    localparam logic [11:0] POS_FIRST_ENTRY   = 12'd8;

    // Configuration channel
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam logic [CFG_IDX_W-1:0] CFG_REPORT_STREAMS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NETWORK_PID    = 2'd1;

    // Result queue
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef enum logic [1:0] {
        KIND_PMT     = 2'd0,
        KIND_NETWORK = 2'd1,
        KIND_STATUS  = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        ST_VALID       = 3'd0,
        ST_BAD_TABLE   = 3'd1,
        ST_SYNTAX_CLR  = 3'd2,
        ST_ZERO_SET    = 3'd3,
        ST_NEED_MORE   = 3'd4,
        ST_BAD_HEADER  = 3'd5
    } t_status;

    typedef struct packed {
        t_kind        kind;
        logic [15:0]  program_number;
        logic [12:0]  pid;
        logic [15:0]  transport_stream_id;
        logic [4:0]   version_number;
        logic         current_next;
        logic [7:0]   section_number;
        logic [7:0]   last_section_number;
        logic [31:0]  crc_value;
        t_status      status;
        logic         last;
    } t_result;

    // Results produced by one accepted byte
    typedef struct packed {
        logic [1:0] cnt;
        t_result    r0;
        t_result    r1;
    } t_push;

endpackage

[hdl/tspat_if.sv]
// Byte input channel
interface tspat_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  data_byte;
    logic        first_byte;
    logic [15:0] buffer_bytes;

    modport source (output valid, data_byte, first_byte, buffer_bytes, input ready);
    modport sink   (input valid, data_byte, first_byte, buffer_bytes, output ready);
endinterface

// Result output channel
interface tspat_out_if;
    import tspat_pkg::*;
    logic        valid;
    logic        ready;
    t_kind       kind;
    logic [15:0] program_number;
    logic [12:0] pid;
    logic [15:0] transport_stream_id;
    logic [4:0]  version_number;
    logic        current_next;
    logic [7:0]  section_number;
    logic [7:0]  last_section_number;
    logic [31:0] crc_value;
    t_status     status;
    logic        last;

    modport source (output valid, kind, program_number, pid, transport_stream_id,
                    version_number, current_next, section_number,
                    last_section_number, crc_value, status, last, input ready);
    modport sink   (input valid, kind, program_number, pid, transport_stream_id,
                    version_number, current_next, section_number,
                    last_section_number, crc_value, status, last, output ready);
endinterface

// Configuration write channel
interface tspat_cfg_if;
    import tspat_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[hdl/tspat_core.sv]
module tspat_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic [7:0]          i_data_byte,
    input  logic                i_first_byte,
    input  logic [15:0]         i_buffer_bytes,
    input  logic                i_report_streams,
    input  logic [12:0]         i_network_pid,
    output tspat_pkg::t_push    o_push
);
    import tspat_pkg::*;

    logic        r_active, n_active;
    logic [11:0] r_pos, n_pos;
    logic [11:0] r_len, n_len;
    logic [15:0] r_avail, n_avail;
    logic [31:0] r_shift, n_shift;
    logic [15:0] r_tsid, n_tsid;
    logic [4:0]  r_version, n_version;
    logic        r_current, n_current;
    logic [7:0]  r_section, n_section;
    logic [7:0]  r_last_sec, n_last_sec;

    logic [31:0] shift_new;
    logic [11:0] len_new;
    logic [15:0] left;
    logic [11:0] len_m9;
    logic [12:0] crc_start;
    logic [12:0] pos_ext;
    t_result     stat;
    t_result     s0;
    t_result     s1;

    assign shift_new = {r_shift[23:0], i_data_byte};
    assign len_new   = {r_len[11:8], i_data_byte};
    assign left      = (r_avail >= PREFIX_BYTES) ? (r_avail - PREFIX_BYTES) : 16'd0;
    assign len_m9    = r_len - MIN_SECTION_LEN;
    assign crc_start = {1'b0, len_m9[11:2], 2'b00} + 13'({1'b0, POS_FIRST_ENTRY});
    assign pos_ext   = {1'b0, r_pos};

    // Status template carrying the stored header fields
    always_comb begin
        stat                     = '0;
        stat.kind                = KIND_STATUS;
        stat.transport_stream_id = r_tsid;
        stat.version_number      = r_version;
        stat.current_next        = r_current;
        stat.section_number      = r_section;
        stat.last_section_number = r_last_sec;
        stat.last                = 1'b1;
    end

    // Stream report templates for a completed entry
    always_comb begin
        s0                = '0;
        s0.kind           = KIND_NETWORK;
        s0.program_number = shift_new[31:16];
        s0.pid            = i_network_pid;
        s1                = '0;
        s1.kind           = KIND_PMT;
        s1.program_number = shift_new[31:16];
        s1.pid            = shift_new[12:0];
        s1.last           = 1'b1;
    end

    // Parser next state and results for the byte being transferred
    always_comb begin
        n_active   = r_active;
        n_pos      = r_pos;
        n_len      = r_len;
        n_avail    = r_avail;
        n_shift    = r_shift;
        n_tsid     = r_tsid;
        n_version  = r_version;
        n_current  = r_current;
        n_section  = r_section;
        n_last_sec = r_last_sec;
        o_push     = '0;

        if (i_accept && i_first_byte) begin
            n_active   = 1'b1;
            n_pos      = 12'd0;
            n_len      = 12'd0;
            n_shift    = 32'd0;
            n_avail    = i_buffer_bytes;
            n_tsid     = 16'd0;
            n_version  = 5'd0;
            n_current  = 1'b0;
            n_section  = 8'd0;
            n_last_sec = 8'd0;
            if (i_data_byte != PAT_TABLE_ID) begin
                o_push.cnt       = 2'd1;
                o_push.r0        = '0;
                o_push.r0.kind   = KIND_STATUS;
                o_push.r0.status = ST_BAD_TABLE;
                o_push.r0.last   = 1'b1;
                n_active         = 1'b0;
            end else begin
                n_pos = 12'd1;
            end
        end else if (i_accept && r_active) begin
            n_pos   = r_pos + 12'd1;
            n_shift = shift_new;
            if (r_pos == POS_LEN_HI) begin
                if (!i_data_byte[7]) begin
                    o_push.cnt       = 2'd1;
                    o_push.r0        = stat;
                    o_push.r0.status = ST_SYNTAX_CLR;
                    n_active         = 1'b0;
                end else if (i_data_byte[6]) begin
                    o_push.cnt       = 2'd1;
                    o_push.r0        = stat;
                    o_push.r0.status = ST_ZERO_SET;
                    n_active         = 1'b0;
                end else begin
                    n_len = {i_data_byte[3:0], 8'd0};
                end
            end else if (r_pos == POS_LEN_LO) begin
                n_len = len_new;
                if (left < {4'd0, len_new}) begin
                    o_push.cnt       = 2'd1;
                    o_push.r0        = stat;
                    o_push.r0.status = ST_NEED_MORE;
                    n_active         = 1'b0;
                end else if (len_new < MIN_SECTION_LEN) begin
                    o_push.cnt       = 2'd1;
                    o_push.r0        = stat;
                    o_push.r0.status = ST_BAD_HEADER;
                    n_active         = 1'b0;
                end
            end else if (r_pos == POS_TSID_LO) begin
                n_tsid = shift_new[15:0];
            end else if (r_pos == POS_VERSION) begin
                n_version = i_data_byte[5:1];
                n_current = i_data_byte[0];
            end else if (r_pos == POS_SECTION) begin
                n_section = i_data_byte;
            end else if (r_pos == POS_LAST_SECTION) begin
                n_last_sec = i_data_byte;
            end else if (r_pos < POS_FIRST_ENTRY) begin
                // table id extension high byte: shift only
            end else if (pos_ext < crc_start) begin
                // last byte of a 4-byte program entry
                if (r_pos[1:0] == 2'b11 && i_report_streams) begin
                    if (shift_new[31:16] != 16'd0) begin
                        o_push.cnt = 2'd2;
                        o_push.r0  = s0;
                        o_push.r1  = s1;
                    end else begin
                        o_push.cnt = 2'd1;
                        o_push.r0  = s1;
                    end
                end
            end else if (pos_ext == crc_start + 13'd3) begin
                o_push.cnt          = 2'd1;
                o_push.r0           = stat;
                o_push.r0.crc_value = shift_new;
                o_push.r0.status    = (r_len[11:10] == 2'b00 && r_section == 8'd0)
                                      ? ST_VALID : ST_BAD_HEADER;
                n_active            = 1'b0;
            end
        end
    end

    // Parser state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active   <= 1'b0;
            r_pos      <= 12'd0;
            r_len      <= 12'd0;
            r_avail    <= 16'd0;
            r_shift    <= 32'd0;
            r_tsid     <= 16'd0;
            r_version  <= 5'd0;
            r_current  <= 1'b0;
            r_section  <= 8'd0;
            r_last_sec <= 8'd0;
        end else begin
            r_active   <= n_active;
            r_pos      <= n_pos;
            r_len      <= n_len;
            r_avail    <= n_avail;
            r_shift    <= n_shift;
            r_tsid     <= n_tsid;
            r_version  <= n_version;
            r_current  <= n_current;
            r_section  <= n_section;
            r_last_sec <= n_last_sec;
        end
    end

endmodule

[hdl/tspat_fifo.sv]
module tspat_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tspat_pkg::t_push    i_push,
    input  logic                i_pop,
    output logic                o_room,
    output logic                o_valid,
    output tspat_pkg::t_result  o_head
);
    import tspat_pkg::*;

    t_result                 r_mem [QDEPTH];
    logic [QPTR_W-1:0]       r_wr, n_wr;
    logic [QPTR_W-1:0]       r_rd, n_rd;
    logic [QCNT_W-1:0]       r_cnt, n_cnt;
    logic                    pop_ok;
    logic [QPTR_W-1:0]       wr_next;

    assign pop_ok  = i_pop && (r_cnt != '0);
    assign wr_next = r_wr + QPTR_W'(1);
    // room for the two results one byte can cause
    assign o_room  = r_cnt <= QCNT_W'(QDEPTH - 2);
    assign o_valid = r_cnt != '0;
    assign o_head  = r_mem[r_rd];

    // Pointer and fill count update
    always_comb begin
        n_wr  = r_wr + QPTR_W'(i_push.cnt);
        n_rd  = pop_ok ? r_rd + QPTR_W'(1) : r_rd;
        n_cnt = r_cnt + QCNT_W'(i_push.cnt) - QCNT_W'(pop_ok);
    end

    // Entry writes, up to two per cycle
    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_mem[r_wr] <= i_push.r0;
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[wr_next] <= i_push.r1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

[hdl/ts_pat_section_parser_top.sv]
// Channel   Modport  Transfer carries
// i_in      sink     data_byte, first_byte, buffer_bytes
// o_res     source   kind, program_number, pid, header fields, crc_value, status, last
// i_cfg     sink     index (0 report_streams, 1 default_network_pid), data
//
// One byte is taken per cycle while i_in.ready is high; its results land in a 4-entry
// result queue at the same edge and leave one per cycle while o_res.ready is high.
// A byte causes at most two results. i_in.ready drops only while the queue holds
// more than two results. Synchronous active-low reset idles the parser and empties the
// queue; the configuration resets to report_streams 1, default_network_pid 0x0010.
module ts_pat_section_parser_top (
    input  logic           i_clk,
    input  logic           i_rst_n,
    tspat_in_if.sink       i_in,
    tspat_out_if.source    o_res,
    tspat_cfg_if.sink      i_cfg
);
    import tspat_pkg::*;

    logic        r_report_streams;
    logic [12:0] r_network_pid;
    logic        in_accept;
    logic        room;
    t_push       push;
    t_result     head;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = room;
    assign in_accept   = i_in.valid && room;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_report_streams <= 1'b1;
            r_network_pid    <= NIT_PID_DEFAULT;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_REPORT_STREAMS: r_report_streams <= i_cfg.data[0];
                CFG_NETWORK_PID:    r_network_pid    <= i_cfg.data[12:0];
                default:            ;
            endcase
        end
    end

    tspat_core u_core (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (in_accept),
        .i_data_byte      (i_in.data_byte),
        .i_first_byte     (i_in.first_byte),
        .i_buffer_bytes   (i_in.buffer_bytes),
        .i_report_streams (r_report_streams),
        .i_network_pid    (r_network_pid),
        .o_push           (push)
    );

    tspat_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (o_res.ready),
        .o_room  (room),
        .o_valid (o_res.valid),
        .o_head  (head)
    );

    // Result payload
    assign o_res.kind                = head.kind;
    assign o_res.program_number      = head.program_number;
    assign o_res.pid                 = head.pid;
    assign o_res.transport_stream_id = head.transport_stream_id;
    assign o_res.version_number      = head.version_number;
    assign o_res.current_next        = head.current_next;
    assign o_res.section_number      = head.section_number;
    assign o_res.last_section_number = head.last_section_number;
    assign o_res.crc_value           = head.crc_value;
    assign o_res.status              = head.status;
    assign o_res.last                = head.last;

endmodule

[bench/testbench.sv]
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import tspat_pkg::*;

    localparam int  HOLD_CYCLES = 80;
    localparam int  SETTLE      = 8;
    localparam time LIMIT_NS    = 10_000_000;

    // One byte on the input channel
    typedef struct {
        logic [7:0]  data;
        logic        first;
        logic [15:0] bufsz;
    } t_pat_byte;

    // Section parser model plus the queue of results it still owes
    class pat_section_scoreboard;
        bit        rep_streams;
        bit [12:0] net_pid;
        bit [11:0] pos;
        bit [11:0] len;
        bit [15:0] avail;
        bit [31:0] shift;
        bit [15:0] tsid;
        bit [4:0]  ver;
        bit        cur;
        bit [7:0]  sect;
        bit [7:0]  last_sect;
        bit        active;
        t_result   owed_results[$];
        int        errors;
        int        checked;
        int        n_pmt;
        int        n_net;
        int        n_status;
        bit [7:0]  status_seen;

        function new();
            rep_streams = 1'b1;
            net_pid     = NIT_PID_DEFAULT;
            active      = 1'b0;
            pos         = '0;
            len         = '0;
            avail       = '0;
            shift       = '0;
            tsid        = '0;
            ver         = '0;
            cur         = 1'b0;
            sect        = '0;
            last_sect   = '0;
        endfunction

        function void note_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            if (idx == CFG_REPORT_STREAMS) begin
                rep_streams = val[0];
            end else if (idx == CFG_NETWORK_PID) begin
                net_pid = val[12:0];
            end
        endfunction

        function void add_stream(t_kind k, bit [15:0] prog, bit [12:0] id, bit is_last);
            t_result r;
            r = '0;
            r.kind           = k;
            r.program_number = prog;
            r.pid            = id;
            r.status         = ST_VALID;
            r.last           = is_last;
            owed_results.insert(owed_results.size(), r);
        endfunction

        // Section status carries whatever header fields have been read so far
        function void add_status(t_status st, bit [31:0] crc);
            t_result r;
            r = '0;
            r.kind                = KIND_STATUS;
            r.transport_stream_id = tsid;
            r.version_number      = ver;
            r.current_next        = cur;
            r.section_number      = sect;
            r.last_section_number = last_sect;
            r.crc_value           = crc;
            r.status              = st;
            r.last                = 1'b1;
            active = 1'b0;
            owed_results.insert(owed_results.size(), r);
        endfunction

        // Advance the parser by one accepted byte
        function void note_byte(logic [7:0] d, logic f, logic [15:0] b);
            int        p;
            int        n;
            int        crc_start;
            bit [15:0] left;
            if (f) begin
                active    = 1'b1;
                pos       = '0;
                len       = '0;
                shift     = '0;
                avail     = b;
                tsid      = '0;
                ver       = '0;
                cur       = 1'b0;
                sect      = '0;
                last_sect = '0;
                if (d != PAT_TABLE_ID) begin
                    add_status(ST_BAD_TABLE, 32'h0);
                end else begin
                    pos = 12'd1;
                end
                return;
            end
            if (!active) begin
                return;
            end
            p     = pos;
            pos   = pos + 12'd1;
            shift = {shift[23:0], d};
            if (p == POS_LEN_HI) begin
                if (!d[7]) begin
                    add_status(ST_SYNTAX_CLR, 32'h0);
                end else if (d[6]) begin
                    add_status(ST_ZERO_SET, 32'h0);
                end else begin
                    len = {d[3:0], 8'h00};
                end
            end else if (p == POS_LEN_LO) begin
                len[7:0] = d;
                left = (avail >= PREFIX_BYTES) ? avail - PREFIX_BYTES : 16'd0;
                if (left < {4'h0, len}) begin
                    add_status(ST_NEED_MORE, 32'h0);
                end else if (len < MIN_SECTION_LEN) begin
                    add_status(ST_BAD_HEADER, 32'h0);
                end
            end else if (p == POS_TSID_LO) begin
                tsid = shift[15:0];
            end else if (p == POS_VERSION) begin
                ver = d[5:1];
                cur = d[0];
            end else if (p == POS_SECTION) begin
                sect = d;
            end else if (p == POS_LAST_SECTION) begin
                last_sect = d;
            end else if (p >= POS_FIRST_ENTRY) begin
                n         = (int'(len) - int'(MIN_SECTION_LEN)) / 4;
                crc_start = int'(POS_FIRST_ENTRY) + 4 * n;
                if (p < crc_start) begin
                    // last byte of a 4-byte program entry
                    if (((p - int'(POS_FIRST_ENTRY)) % 4) == 3 && rep_streams) begin
                        if (shift[31:16] != 16'h0) begin
                            add_stream(KIND_NETWORK, shift[31:16], net_pid, 1'b0);
                        end
                        add_stream(KIND_PMT, shift[31:16], shift[12:0], 1'b1);
                    end
                end else if (p == crc_start + 3) begin
                    if (len[11:10] == 2'b00 && sect == 8'h00) begin
                        add_status(ST_VALID, shift);
                    end else begin
                        add_status(ST_BAD_HEADER, shift);
                    end
                end
            end
        endfunction

        function void check_field(string name, logic [31:0] e, logic [31:0] a);
            if (e !== a) begin
                errors++;
                $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, e, a);
            end
        endfunction

        function void match_result(t_result act);
            t_result e;
            if (owed_results.size() == 0) begin
                errors++;
                $display("%0t: result with none expected, expected nothing actual kind %0d status %0d",
                         $time, act.kind, act.status);
                return;
            end
            e = owed_results.pop_front();
            checked++;
            if (e.kind == KIND_PMT) n_pmt++;
            else if (e.kind == KIND_NETWORK) n_net++;
            else begin
                n_status++;
                status_seen[e.status] = 1'b1;
            end
            check_field("kind", e.kind, act.kind);
            check_field("program_number", e.program_number, act.program_number);
            check_field("pid", e.pid, act.pid);
            check_field("transport_stream_id", e.transport_stream_id, act.transport_stream_id);
            check_field("version_number", e.version_number, act.version_number);
            check_field("current_next", e.current_next, act.current_next);
            check_field("section_number", e.section_number, act.section_number);
            check_field("last_section_number", e.last_section_number,
                        act.last_section_number);
            check_field("crc_value", e.crc_value, act.crc_value);
            check_field("status", e.status, act.status);
            check_field("last", e.last, act.last);
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    tspat_in_if  in_if();
    tspat_out_if res_if();
    tspat_cfg_if cfg_if();

    ts_pat_section_parser_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_res   (res_if),
        .i_cfg   (cfg_if)
    );

    pat_section_scoreboard sb = new();
    t_pat_byte             byte_q[$];
    logic [7:0]            sec_bytes[$];
    bit                    hold_off;
    bit                    calm;
    int                    n_bytes;
    int                    n_writes;

    // Clock
    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // Hard stop
    initial begin
        #(LIMIT_NS);
        $display("testbench NOT OK");
        $finish;
    end

    // Watch all three channels; check outputs before noting new input
    always @(posedge i_clk) begin : bus_monitor
        t_result seen;
        if (i_rst_n) begin
            if (res_if.valid && res_if.ready) begin
                seen.kind                = res_if.kind;
                seen.program_number      = res_if.program_number;
                seen.pid                 = res_if.pid;
                seen.transport_stream_id = res_if.transport_stream_id;
                seen.version_number      = res_if.version_number;
                seen.current_next        = res_if.current_next;
                seen.section_number      = res_if.section_number;
                seen.last_section_number = res_if.last_section_number;
                seen.crc_value           = res_if.crc_value;
                seen.status              = res_if.status;
                seen.last                = res_if.last;
                sb.match_result(seen);
            end
            if (in_if.valid && in_if.ready) begin
                n_bytes++;
                sb.note_byte(in_if.data_byte, in_if.first_byte, in_if.buffer_bytes);
            end
            if (cfg_if.valid && cfg_if.ready) begin
                n_writes++;
                sb.note_reg(cfg_if.index, cfg_if.data);
            end
        end
    end

    // Result sink: random stall bursts, one long hold-off on request
    initial begin : result_sink
        res_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off) begin
                res_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_off = 1'b0;
                res_if.ready <= 1'b1;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                res_if.ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
                res_if.ready <= 1'b1;
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    task automatic put_byte(input logic [7:0] d, input logic f, input logic [15:0] b);
        t_pat_byte it;
        it.data  = d;
        it.first = f;
        it.bufsz = b;
        byte_q.insert(byte_q.size(), it);
    endtask

    // Queue the first count bytes of sec_bytes as one section
    task automatic put_section(input int bufsz, input int count);
        for (int i = 0; i < count && i < sec_bytes.size(); i++) begin
            put_byte(sec_bytes[i], i == 0, (i == 0) ? 16'(bufsz) : 16'($urandom));
        end
    endtask

    // Well-formed section with n entries and pad spare bytes after the CRC
    task automatic build_section(input int n, input int pad);
        bit [11:0] len;
        bit [15:0] prog;
        len = 12'(9 + 4 * n + pad);
        sec_bytes.delete();
        sec_bytes.insert(sec_bytes.size(), PAT_TABLE_ID);
        sec_bytes.insert(sec_bytes.size(), {2'b10, 2'($urandom_range(0, 3)), len[11:8]});
        sec_bytes.insert(sec_bytes.size(), len[7:0]);
        sec_bytes.insert(sec_bytes.size(), 8'($urandom));
        sec_bytes.insert(sec_bytes.size(), 8'($urandom));
        sec_bytes.insert(sec_bytes.size(), 8'($urandom));
        sec_bytes.insert(sec_bytes.size(),
                         ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'h00);
        sec_bytes.insert(sec_bytes.size(), 8'($urandom));
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 7))
                0, 1: prog = 16'h0000;
                2:    prog = 16'hFFFF;
                default: prog = 16'($urandom);
            endcase
            sec_bytes.insert(sec_bytes.size(), prog[15:8]);
            sec_bytes.insert(sec_bytes.size(), prog[7:0]);
            sec_bytes.insert(sec_bytes.size(), 8'($urandom));
            sec_bytes.insert(sec_bytes.size(), 8'($urandom));
        end
        repeat (4 + pad) sec_bytes.insert(sec_bytes.size(), 8'($urandom));
    endtask

    // Mostly good sections, some broken or truncated ones, some noise
    task automatic gen_traffic(input int target);
        int pick;
        int n;
        int pad;
        int len;
        int bufsz;
        target += byte_q.size();
        while (byte_q.size() < target) begin
            pick  = $urandom_range(0, 19);
            n     = $urandom_range(0, 6);
            pad   = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
            build_section(n, pad);
            len   = 9 + 4 * n + pad;
            bufsz = len + 3;
            if ($urandom_range(0, 3) == 0) bufsz += $urandom_range(0, 65535 - bufsz);
            if (pick <= 12) begin
                put_section(bufsz, sec_bytes.size());
                // trailing bytes after the end are ignored
                if ($urandom_range(0, 3) == 0) begin
                    repeat ($urandom_range(1, 3)) put_byte(8'($urandom), 1'b0, 16'($urandom));
                end
            end else if (pick <= 14) begin
                put_section(bufsz, $urandom_range(1, sec_bytes.size() - 1));
            end else if (pick == 15) begin
                sec_bytes[0] = 8'($urandom_range(1, 255));
                put_section(bufsz, $urandom_range(1, 4));
            end else if (pick == 16) begin
                if ($urandom_range(0, 1) == 0) sec_bytes[1][7] = 1'b0;
                else sec_bytes[1][6] = 1'b1;
                put_section(bufsz, $urandom_range(2, 6));
            end else if (pick == 17) begin
                put_section($urandom_range(0, len + 2), $urandom_range(3, sec_bytes.size()));
            end else if (pick == 18) begin
                sec_bytes[1][3:0] = 4'h0;
                sec_bytes[2] = 8'($urandom_range(0, 8));
                put_section(bufsz, $urandom_range(3, 8));
            end else begin
                repeat ($urandom_range(1, 4)) put_byte(8'($urandom), 1'b0, 16'($urandom));
            end
        end
    endtask

    // Drive every queued byte, with random idle bursts unless calm
    task automatic send_bytes();
        t_pat_byte it;
        while (byte_q.size() != 0) begin
            it = byte_q.pop_front();
            if (!calm && $urandom_range(0, 4) == 0) begin
                in_if.valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
            in_if.valid        <= 1'b1;
            in_if.data_byte    <= it.data;
            in_if.first_byte   <= it.first;
            in_if.buffer_bytes <= it.bufsz;
            do @(posedge i_clk); while (!in_if.ready);
        end
        in_if.valid <= 1'b0;
    endtask

    // Write both registers back to back
    task automatic set_config(input bit rep, input logic [12:0] pid);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= CFG_REPORT_STREAMS;
        cfg_if.data  <= {12'h000, rep};
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.index <= CFG_NETWORK_PID;
        cfg_if.data  <= pid;
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic wait_drained();
        do @(posedge i_clk); while (sb.owed_results.size() != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    initial begin : stimulus
        i_rst_n             = 1'b0;
        in_if.valid         = 1'b0;
        in_if.data_byte     = '0;
        in_if.first_byte    = 1'b0;
        in_if.buffer_bytes  = '0;
        cfg_if.valid        = 1'b0;
        cfg_if.index        = CFG_REPORT_STREAMS;
        cfg_if.data         = '0;
        hold_off            = 1'b0;
        calm                = 1'b0;
        n_bytes             = 0;
        n_writes            = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: idle byte, header errors, saturated prefix, restart, max entry
        put_byte(8'h00, 1'b0, 16'h0000);
        put_byte(8'hFF, 1'b1, 16'h0010);
        put_byte(8'h00, 1'b1, 16'h0100);
        put_byte(8'h7F, 1'b0, 16'h0000);
        put_byte(8'h00, 1'b1, 16'h0100);
        put_byte(8'hC5, 1'b0, 16'h0000);
        put_byte(8'h00, 1'b1, 16'h0000);
        put_byte(8'hBF, 1'b0, 16'h0000);
        put_byte(8'hFF, 1'b0, 16'h0000);
        put_byte(8'h00, 1'b1, 16'hFFFF);
        put_byte(8'hB0, 1'b0, 16'h0000);
        put_byte(8'h08, 1'b0, 16'h0000);
        put_byte(8'h00, 1'b1, 16'h0040);
        put_byte(8'hB0, 1'b0, 16'h0000);
        build_section(1, 0);
        sec_bytes[6] = 8'h00;
        for (int i = 8; i < 12; i++) sec_bytes[i] = 8'hFF;
        put_section(sec_bytes.size() + 3, sec_bytes.size());
        put_byte(8'hFF, 1'b0, 16'hFFFF);
        send_bytes();
        wait_drained();

        // Random traffic at reset configuration
        gen_traffic(95);
        send_bytes();
        wait_drained();

        set_config(1'b1, 13'h0000);
        gen_traffic(95);
        send_bytes();
        wait_drained();

        // Long result stall while bytes keep coming
        set_config(1'b1, 13'h1FFF);
        hold_off = 1'b1;
        gen_traffic(95);
        send_bytes();
        wait_drained();

        set_config(1'b0, 13'($urandom));
        gen_traffic(95);
        send_bytes();
        wait_drained();

        set_config(1'b1, 13'($urandom));
        gen_traffic(95);
        send_bytes();
        wait_drained();

        // Final stretch at full rate on both sides
        calm = 1'b1;
        set_config(1'b1, 13'($urandom));
        gen_traffic(95);
        send_bytes();
        wait_drained();

        if (sb.owed_results.size() != 0) begin
            sb.errors++;
            $display("%0t: results missing, expected %0d more actual 0",
                     $time, sb.owed_results.size());
        end
        $display("covered %0d section bytes and %0d register writes; %0d results checked",
                 n_bytes, n_writes, sb.checked);
        $display("  stream %0d, network %0d, status %0d, status codes seen %b",
                 sb.n_pmt, sb.n_net, sb.n_status, sb.status_seen[5:0]);
        if (sb.errors == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule

[filelist.f]
hdl/tspat_pkg.sv
hdl/tspat_if.sv
hdl/tspat_core.sv
hdl/tspat_fifo.sv
hdl/ts_pat_section_parser_top.sv
bench/testbench.sv
